/* src/hrsp_pkg.sv */
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types and constants of the hybrid region / stride / next-line
// prefetcher.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int ADDR_W            = 64;
    localparam int TABLE_ENTRIES     = 256;
    localparam int REGION_BITS       = 12;
    localparam int LINE_BITS         = 6;
    localparam int REGION_LINES      = 4;
    localparam int STRIDE_LIMIT_BITS = 20;

    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_STRIDE = 2'd1;
    localparam logic [1:0] KIND_NEXT   = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] access_addr;
        logic [ADDR_W-1:0] instr_ptr;
    } t_access;

    typedef struct packed {
        logic [ADDR_W-1:0] pf_addr;
        logic [1:0]        prefetch_kind;
        logic              last_of_run;
    } t_prefetch;

endpackage

/* src/hrsp_alu.sv */
// ----------------------------------------------------------------------------
// hrsp_alu
// Shared 64-bit adder/subtractor used by every address computation.
// ----------------------------------------------------------------------------
module hrsp_alu (
    input  logic [hrsp_pkg::ADDR_W-1:0] i_a,
    input  logic [hrsp_pkg::ADDR_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [hrsp_pkg::ADDR_W-1:0] o_sum
);
    import hrsp_pkg::*;

    assign o_sum = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

/* src/hrsp_table.sv */
// ----------------------------------------------------------------------------
// hrsp_table
// Direct-mapped IP table: one write port, one read port with registered data.
// Each word holds a valid bit, the IP tag, the last address and the stride.
// ----------------------------------------------------------------------------
module hrsp_table #(
    parameter int TABLE_ENTRIES = hrsp_pkg::TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES),
    parameter int TAG_W         = hrsp_pkg::ADDR_W - IDX_W
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [IDX_W-1:0]            i_wr_idx,
    input  logic                        i_wr_valid,
    input  logic [TAG_W-1:0]            i_wr_tag,
    input  logic [hrsp_pkg::ADDR_W-1:0] i_wr_last,
    input  logic [hrsp_pkg::ADDR_W-1:0] i_wr_stride,
    input  logic                        i_rd_en,
    input  logic [IDX_W-1:0]            i_rd_idx,
    output logic                        o_rd_valid,
    output logic [TAG_W-1:0]            o_rd_tag,
    output logic [hrsp_pkg::ADDR_W-1:0] o_rd_last,
    output logic [hrsp_pkg::ADDR_W-1:0] o_rd_stride
);
    import hrsp_pkg::*;

    localparam int WORD_W = 1 + TAG_W + 2 * ADDR_W;

    logic [WORD_W-1:0] r_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_valid, i_wr_tag, i_wr_last, i_wr_stride};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign {o_rd_valid, o_rd_tag, o_rd_last, o_rd_stride} = r_rd_data;

endmodule

/* src/hybrid_region_stride_prefetcher.sv */
// ----------------------------------------------------------------------------
// hybrid_region_stride_prefetcher
// Turns each demand access into a run of prefetch addresses: region start
// lines on a region change, an IP-stride prediction, and the next line.
//
// Usage:
// - Input channel i_valid/o_stall carries one access item (address and IP).
//   Output channel o_valid/i_stall carries prefetch items; the last item of
//   each run has last_of_run set.
// - One access is handled at a time. After acceptance the table is read,
//   then one prefetch is produced per cycle into the output register while
//   that register is free (empty or taken by the receiver). An access yields
//   N prefetches (1 to REGION_LINES + 2): one in the common next-line-only
//   case, two with a stride hit. The single shared adder computes the
//   addresses one at a time.
// - The first prefetch reaches o_valid from the output register after S_LOOK.
// - After reset a clearing pass walks the IP table, one entry per cycle, over
//   all TABLE_ENTRIES entries (256 by default); o_stall is high meanwhile.
// - When the receiver stalls, the output register holds its item and the
//   sequencer waits; no prefetch is dropped. o_stall stays high until the
//   run is fully handed to the output register.
// ----------------------------------------------------------------------------
module hybrid_region_stride_prefetcher #(
    parameter int TABLE_ENTRIES = hrsp_pkg::TABLE_ENTRIES,
    parameter int REGION_BITS   = hrsp_pkg::REGION_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  hrsp_pkg::t_access   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output hrsp_pkg::t_prefetch o_item
);
    import hrsp_pkg::*;

    // TABLE_ENTRIES must be a power of two.
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TAG_W  = ADDR_W - IDX_W;
    localparam int REG_W  = ADDR_W - REGION_BITS;
    localparam int LINE_W = (REGION_LINES > 1) ? $clog2(REGION_LINES) : 1;
    localparam int LIM    = STRIDE_LIMIT_BITS;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOK   = 6'b000100,
        S_REGION = 6'b001000,
        S_STRIDE = 6'b010000,
        S_NEXT   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_idx, n_clr_idx;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [REG_W-1:0]    r_prev_region, n_prev_region;
    logic                r_prev_valid, n_prev_valid;
    logic                r_region_chg, n_region_chg;
    logic                r_stride_ok, n_stride_ok;
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_ip;
    logic [ADDR_W-1:0]   r_old_stride;
    t_prefetch           r_out, n_out;

    logic                accept;
    logic                out_free;
    logic                hit;
    logic [REG_W-1:0]    in_region;

    logic                tbl_wr_en;
    logic [IDX_W-1:0]    tbl_wr_idx;
    logic                tbl_wr_valid;
    logic [TAG_W-1:0]    tbl_wr_tag;
    logic [ADDR_W-1:0]   tbl_wr_last;
    logic [ADDR_W-1:0]   tbl_wr_stride;
    logic                tbl_rd_valid;
    logic [TAG_W-1:0]    tbl_rd_tag;
    logic [ADDR_W-1:0]   tbl_rd_last;
    logic [ADDR_W-1:0]   tbl_rd_stride;

    logic [ADDR_W-1:0]   alu_a, alu_b, alu_sum;
    logic                alu_sub;

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign in_region = i_item.access_addr[ADDR_W-1:REGION_BITS];
    assign hit       = tbl_rd_valid && (tbl_rd_tag == r_ip[ADDR_W-1:IDX_W]);

    hrsp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .TAG_W         (TAG_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (tbl_wr_en),
        .i_wr_idx    (tbl_wr_idx),
        .i_wr_valid  (tbl_wr_valid),
        .i_wr_tag    (tbl_wr_tag),
        .i_wr_last   (tbl_wr_last),
        .i_wr_stride (tbl_wr_stride),
        .i_rd_en     (accept),
        .i_rd_idx    (i_item.instr_ptr[IDX_W-1:0]),
        .o_rd_valid  (tbl_rd_valid),
        .o_rd_tag    (tbl_rd_tag),
        .o_rd_last   (tbl_rd_last),
        .o_rd_stride (tbl_rd_stride)
    );

    hrsp_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = r_addr;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_LOOK: begin
                alu_b   = tbl_rd_last;
                alu_sub = 1'b1;
            end
            S_REGION: begin
                alu_a = {r_addr[ADDR_W-1:REGION_BITS], {REGION_BITS{1'b0}}};
                alu_b = ADDR_W'(r_line) << LINE_BITS;
            end
            S_STRIDE: alu_b = r_old_stride;
            S_NEXT:   alu_b = ADDR_W'(1) << LINE_BITS;
            default:  alu_b = '0;
        endcase
    end

    // Table writes: zero words during the clearing pass, the update in S_LOOK.
    always_comb begin
        tbl_wr_en     = 1'b0;
        tbl_wr_idx    = r_ip[IDX_W-1:0];
        tbl_wr_valid  = 1'b1;
        tbl_wr_tag    = r_ip[ADDR_W-1:IDX_W];
        tbl_wr_last   = r_addr;
        tbl_wr_stride = hit ? alu_sum : '0;
        case (r_state)
            S_CLEAR: begin
                tbl_wr_en     = 1'b1;
                tbl_wr_idx    = r_clr_idx;
                tbl_wr_valid  = 1'b0;
                tbl_wr_tag    = '0;
                tbl_wr_last   = '0;
                tbl_wr_stride = '0;
            end
            S_LOOK:  tbl_wr_en = 1'b1;
            default: tbl_wr_en = 1'b0;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_clr_idx     = r_clr_idx;
        n_line        = r_line;
        n_prev_region = r_prev_region;
        n_prev_valid  = r_prev_valid;
        n_region_chg  = r_region_chg;
        n_stride_ok   = r_stride_ok;
        n_out         = r_out;
        n_out_valid   = r_out_valid && i_stall;

        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == {IDX_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_region_chg  = r_prev_valid && (r_prev_region != in_region);
                    n_prev_region = in_region;
                    n_prev_valid  = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                // On a table hit, the stride qualifies when it is nonzero and lies
                // strictly between minus and plus two to the limit.
                n_stride_ok = hit && (tbl_rd_stride[LIM-1:0] != '0) &&
                              ((tbl_rd_stride[ADDR_W-1:LIM] == '0) ||
                               (tbl_rd_stride[ADDR_W-1:LIM] == '1));
                n_line = '0;
                if (r_region_chg) begin
                    n_state = S_REGION;
                end else if (n_stride_ok) begin
                    n_state = S_STRIDE;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_REGION: begin
                if (out_free) begin
                    n_out       = '{pf_addr: alu_sum, prefetch_kind: KIND_REGION,
                                    last_of_run: 1'b0};
                    n_out_valid = 1'b1;
                    n_line      = r_line + LINE_W'(1);
                    if (r_line == LINE_W'(REGION_LINES - 1)) begin
                        n_state = r_stride_ok ? S_STRIDE : S_NEXT;
                    end
                end
            end
            S_STRIDE: begin
                if (out_free) begin
                    n_out       = '{pf_addr: alu_sum, prefetch_kind: KIND_STRIDE,
                                    last_of_run: 1'b0};
                    n_out_valid = 1'b1;
                    n_state     = S_NEXT;
                end
            end
            S_NEXT: begin
                if (out_free) begin
                    n_out       = '{pf_addr: alu_sum, prefetch_kind: KIND_NEXT,
                                    last_of_run: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_line        <= '0;
            r_prev_region <= '0;
            r_prev_valid  <= 1'b0;
            r_region_chg  <= 1'b0;
            r_stride_ok   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_idx     <= n_clr_idx;
            r_line        <= n_line;
            r_prev_region <= n_prev_region;
            r_prev_valid  <= n_prev_valid;
            r_region_chg  <= n_region_chg;
            r_stride_ok   <= n_stride_ok;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_addr <= i_item.access_addr;
            r_ip   <= i_item.instr_ptr;
        end
        if (r_state == S_LOOK) begin
            r_old_stride <= tbl_rd_stride;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
